[hdl/slew_sensing_air_enhancer_unit_macros.svh]
// Assertion macros shared by the slew-sensing air enhancer modules.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef SLEW_SENSING_AIR_ENHANCER_UNIT_MACROS_SVH
`define SLEW_SENSING_AIR_ENHANCER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SSEU_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SSEU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/sseu_pkg.sv]
// Package for the slew-sensing air enhancer: widths, constants and the
// command and status types between the controller and the datapath. No dependencies.
`timescale 1ns / 1ps

package sseu_pkg;

	// Configuration register widths and reset values.
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 24;
	localparam int unsigned TGT_W     = 23;
	localparam int unsigned THR_W     = 24;
	localparam int unsigned INT_W     = 23;
	localparam int unsigned WET_W     = 17;
	localparam logic [THR_W-1:0] THRESH_RESET = 24'd8388608;
	localparam logic [WET_W-1:0] WET_ONE      = 17'd65536;

	// Shared multiplier operand and product widths.
	localparam int unsigned MUL_A_W = 34;
	localparam int unsigned MUL_B_W = 29;
	localparam int unsigned PROD_W  = 63;

	// Gain and sensing widths.
	localparam int unsigned GAIN_W  = 24;
	localparam int unsigned SENSE_W = 25;
	localparam int unsigned EXC_W   = 34;
	localparam int unsigned Q_W     = 28;
	localparam int unsigned R_W     = 33;
	localparam int unsigned RL_W    = 17;
	localparam logic [SENSE_W-1:0] SENSE_MAX = 25'd16777216;
	localparam logic signed [GAIN_W-1:0] GAIN_FLOOR = -24'sd1048576;

	// Rounding offsets for the two divisions by 1.3.
	localparam logic [26:0] Q_RND = 27'd27262976;
	localparam logic [26:0] R_RND = 27'd109051904;

	// Divide-by-13 digit unit: 12 quotient bits per step.
	localparam int unsigned DIV_W       = 36;
	localparam int unsigned DIG_W       = 12;
	localparam int unsigned REM_W       = 4;
	localparam int unsigned DIV_STEPS   = DIV_W / DIG_W;
	localparam int unsigned STEP_W      = $clog2(DIV_STEPS);
	localparam int unsigned DIVISOR     = 13;
	localparam int unsigned RECIP_SHIFT = 20;
	localparam logic [16:0] RECIP13     = 17'd80660;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET,
		REG_THRESH,
		REG_INTENS,
		REG_WET
	} cfg_reg_t;

	// Operand selection for the shared multiplier.
	typedef enum logic [2:0] {
		MS_P,
		MS_QQ,
		MS_RH,
		MS_RL,
		MS_G,
		MS_X
	} mul_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     div_load;
		logic     div_src_r;
		logic     div_step;
		logic     acc_en;
		logic     sense_en;
		logic     gain_en;
		logic     g_en;
		logic     commit;
	} sseu_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_blocked;
	} sseu_sts_t;

endpackage

[hdl/sseu_div13.sv]
// Digit-serial divide-by-13 unit, 12 quotient bits per step.
// Depends on sseu_pkg.
`timescale 1ns / 1ps

module sseu_div13 (
	input  logic                       clk,
	input  logic                       load,
	input  logic                       step,
	input  logic [sseu_pkg::DIV_W-1:0] din,
	output logic [sseu_pkg::DIV_W-1:0] quo
);
	import sseu_pkg::*;

	localparam int unsigned V_W = REM_W + DIG_W;

	logic [REM_W-1:0] rem_q;
	logic [DIV_W-1:0] dvd_q;
	logic [DIV_W-1:0] quo_q;
	logic [V_W-1:0]   v;
	logic [V_W+16:0]  qm;
	logic [DIG_W-1:0] qd;
	logic [REM_W-1:0] rem_n;

	// One digit: partial remainder over 13 by a reciprocal multiply, then the new remainder.
	always_comb begin
		v     = {rem_q, dvd_q[DIV_W-1 -: DIG_W]};
		qm    = (V_W+17)'(v) * (V_W+17)'(RECIP13);
		qd    = qm[RECIP_SHIFT +: DIG_W];
		rem_n = REM_W'(v - V_W'(qd) * V_W'(DIVISOR));
	end

	// Dividend shifts out from the top while quotient digits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			dvd_q <= din;
			quo_q <= '0;
		end else if (step) begin
			rem_q <= rem_n;
			dvd_q <= dvd_q << DIG_W;
			quo_q <= {quo_q[DIV_W-DIG_W-1:0], qd};
		end
	end

	assign quo = quo_q;

endmodule

[hdl/sseu_ctrl.sv]
// Controller state machine for the slew-sensing air enhancer.
// Sequences the shared multiplier and divider; depends on sseu_pkg and the macro header.
`timescale 1ns / 1ps
`include "slew_sensing_air_enhancer_unit_macros.svh"

module sseu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output sseu_pkg::sseu_cmd_t cmd,
	input  sseu_pkg::sseu_sts_t sts
);
	import sseu_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_P,
		S_PREP_Q,
		S_DIV_Q,
		S_MUL_QQ,
		S_PREP_R,
		S_DIV_R,
		S_MUL_RH,
		S_MUL_RL,
		S_SENSE,
		S_GAIN,
		S_MUL_G,
		S_SCALE,
		S_MUL_X,
		S_OUT
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              last_step;

	assign last_step = (step_q == STEP_W'(DIV_STEPS - 1));
	assign in_stall  = (state_q != S_IDLE);

	// State register and divider step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_MUL_P;
				end
				S_MUL_P:  state_q <= S_PREP_Q;
				S_PREP_Q: begin
					step_q  <= '0;
					state_q <= S_DIV_Q;
				end
				S_DIV_Q: begin
					step_q <= step_q + STEP_W'(1);
					if (last_step) state_q <= S_MUL_QQ;
				end
				S_MUL_QQ: state_q <= S_PREP_R;
				S_PREP_R: begin
					step_q  <= '0;
					state_q <= S_DIV_R;
				end
				S_DIV_R: begin
					step_q <= step_q + STEP_W'(1);
					if (last_step) state_q <= S_MUL_RH;
				end
				S_MUL_RH: state_q <= S_MUL_RL;
				S_MUL_RL: state_q <= S_SENSE;
				S_SENSE:  state_q <= S_GAIN;
				S_GAIN:   state_q <= S_MUL_G;
				S_MUL_G:  state_q <= S_SCALE;
				S_SCALE:  state_q <= S_MUL_X;
				S_MUL_X:  state_q <= S_OUT;
				S_OUT: begin
					if (!sts.out_blocked) state_q <= S_IDLE;
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// Command decode for the datapath.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:   cmd.load = in_valid;
			S_MUL_P: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_P;
			end
			S_PREP_Q: cmd.div_load = 1'b1;
			S_DIV_Q:  cmd.div_step = 1'b1;
			S_MUL_QQ: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_QQ;
			end
			S_PREP_R: begin
				cmd.div_load  = 1'b1;
				cmd.div_src_r = 1'b1;
			end
			S_DIV_R:  cmd.div_step = 1'b1;
			S_MUL_RH: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_RH;
			end
			S_MUL_RL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_RL;
				cmd.acc_en  = 1'b1;
			end
			S_SENSE:  cmd.sense_en = 1'b1;
			S_GAIN:   cmd.gain_en = 1'b1;
			S_MUL_G: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_G;
			end
			S_SCALE:  cmd.g_en = 1'b1;
			S_MUL_X: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_X;
			end
			S_OUT:    cmd.commit = !sts.out_blocked;
			default:  cmd = '0;
		endcase
	end

	// An accepted transaction holds off the input until its result is written.
	`SSEU_ASSERT_NEXT(a_accept_stalls, in_valid && !in_stall, in_stall, "input not stalled after accept")
	// A result is written only into a free output register.
	`SSEU_ASSERT_IMPL(a_commit_free, cmd.commit, !sts.out_blocked, "commit into blocked output")
	// Loading the divider is always followed by a digit step.
	`SSEU_ASSERT_NEXT(a_load_then_step, cmd.div_load, cmd.div_step, "divider load without step")
	// The step counter stays within the digit count while dividing.
	`SSEU_ASSERT_IMPL(a_step_range, cmd.div_step, step_q < STEP_W'(DIV_STEPS), "divider step overrun")

endmodule

[hdl/sseu_dp.sv]
// Datapath for the slew-sensing air enhancer: sample history, shared multiplier,
// gain state and output register. Depends on sseu_pkg, sseu_div13 and the macro header.
`timescale 1ns / 1ps
`include "slew_sensing_air_enhancer_unit_macros.svh"

module sseu_dp #(
	parameter int unsigned SAMPLE_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sseu_pkg::sseu_cmd_t                  cmd,
	output sseu_pkg::sseu_sts_t                  sts,
	input  logic signed [SAMPLE_BITS-1:0]        in_sample,
	input  logic                                 block_last,
	input  logic signed [sseu_pkg::TGT_W-1:0]    target_gain,
	input  logic        [sseu_pkg::THR_W-1:0]    slew_threshold,
	input  logic        [sseu_pkg::INT_W-1:0]    sense_intensity,
	input  logic        [sseu_pkg::WET_W-1:0]    wet_mix,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [SAMPLE_BITS-1:0]        out_sample,
	output logic                                 out_block_last
);
	import sseu_pkg::*;

	localparam int unsigned UP_SHIFT  = (SAMPLE_BITS < 24) ? 24 - SAMPLE_BITS : 0;
	localparam int unsigned DN_SHIFT  = (SAMPLE_BITS > 24) ? SAMPLE_BITS - 24 : 0;
	localparam int unsigned CMP_SHIFT = 32 - SAMPLE_BITS;
	localparam int unsigned OUT_SHIFT = 53 - SAMPLE_BITS;
	localparam int unsigned XW        = SAMPLE_BITS + 24;
	localparam int unsigned YW        = SAMPLE_BITS + 4;
	localparam int unsigned DW        = SAMPLE_BITS + 1;
	localparam logic signed [PROD_W-1:0] G_RND = 63'sd32768;
	localparam logic signed [PROD_W-1:0] O_RND = {{(PROD_W-1){1'b0}}, 1'b1} << (OUT_SHIFT - 1);
	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// Bring a sample to Q1.23: scale up when narrower, floor when wider.
	function automatic logic signed [23:0] to_q23(input logic signed [SAMPLE_BITS-1:0] v);
		logic signed [XW-1:0] w;
		w = XW'(v);
		w = (w <<< UP_SHIFT) >>> DN_SHIFT;
		return w[23:0];
	endfunction

	// Sample history and gain state.
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic                          last_q;
	logic signed [SAMPLE_BITS-1:0] prev_one_q;
	logic signed [SAMPLE_BITS-1:0] prev_two_q;
	logic signed [GAIN_W-1:0]      smoothed_gain_q;

	// Working registers.
	logic signed [EXC_W-1:0]   excess_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic        [55:0]        acc_q;
	logic        [SENSE_W-1:0] sense_q;
	logic signed [GAIN_W-1:0]  g_q;

	// Output register.
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;
	logic                          out_block_last_q;

	// Combinational terms.
	logic signed [23:0]          xn, p1n, p2n;
	logic signed [24:0]          d1, d0;
	logic signed [25:0]          e;
	logic signed [MUL_A_W-1:0]   mul_a;
	logic signed [MUL_B_W-1:0]   mul_b;
	logic signed [PROD_W-1:0]    prod_d;
	logic        [WET_W-1:0]     wet_eff;
	logic        [PROD_W-1:0]    ap_full;
	logic        [49:0]          ap;
	logic        [53:0]          nq;
	logic        [59:0]          nr;
	logic        [DIV_W-1:0]     div_din;
	logic        [DIV_W-1:0]     div_quo;
	logic        [56:0]          sense_sum;
	logic        [32:0]          sense_raw;
	logic        [SENSE_W-1:0]   sense_d;
	logic signed [26:0]          gain_sum;
	logic signed [26:0]          gain_half;
	logic signed [GAIN_W-1:0]    gain_d;
	logic signed [PROD_W-1:0]    g_rnd;
	logic signed [PROD_W-1:0]    g_shift;
	logic signed [DW-1:0]        diff;
	logic signed [EXC_W-1:0]     c32, t32, excess_d;
	logic signed [PROD_W-1:0]    o_rnd;
	logic signed [PROD_W-1:0]    adj_full;
	logic signed [YW-1:0]        adj;
	logic signed [YW-1:0]        y;
	logic signed [SAMPLE_BITS-1:0] y_sat;

	// Second differences of the normalized samples.
	always_comb begin
		xn  = to_q23(x_q);
		p1n = to_q23(prev_one_q);
		p2n = to_q23(prev_two_q);
		d1  = 25'(xn) - 25'(p1n);
		d0  = 25'(p1n) - 25'(p2n);
		e   = 26'(d1) - 26'(d0);
	end

	// Wet fraction above one acts as one.
	assign wet_eff = (wet_mix > WET_ONE) ? WET_ONE : wet_mix;

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			MS_P: begin
				mul_a = MUL_A_W'(d1);
				mul_b = MUL_B_W'(e);
			end
			MS_QQ: begin
				mul_a = MUL_A_W'(div_quo[Q_W-1:0]);
				mul_b = MUL_B_W'(div_quo[Q_W-1:0]);
			end
			MS_RH: begin
				mul_a = MUL_A_W'(div_quo[R_W-1:RL_W]);
				mul_b = MUL_B_W'(sense_intensity);
			end
			MS_RL: begin
				mul_a = MUL_A_W'(div_quo[RL_W-1:0]);
				mul_b = MUL_B_W'(sense_intensity);
			end
			MS_G: begin
				mul_a = MUL_A_W'(smoothed_gain_q);
				mul_b = MUL_B_W'(wet_eff);
			end
			MS_X: begin
				mul_a = excess_q;
				mul_b = MUL_B_W'(g_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;

	// Dividends for the two divisions by 1.3, pre-shifted so that only 13 remains.
	always_comb begin
		ap_full = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
		ap      = ap_full[49:0];
		nq      = (54'(ap) << 3) + (54'(ap) << 1) + 54'(Q_RND);
		nr      = (60'(prod_q[55:0]) << 3) + (60'(prod_q[55:0]) << 1) + 60'(R_RND);
		div_din = cmd.div_src_r ? nr[59:24] : DIV_W'(nq[53:22]);
	end

	sseu_div13 u_div13 (
		.clk  (clk),
		.load (cmd.div_load),
		.step (cmd.div_step),
		.din  (div_din),
		.quo  (div_quo)
	);

	// Sense from the two partial products, rounded and saturated at 16.0.
	always_comb begin
		sense_sum = 57'(acc_q) + 57'(prod_q[39:0]) + 57'(24'd8388608);
		sense_raw = sense_sum[56:24];
		sense_d   = (sense_raw > 33'(SENSE_MAX)) ? SENSE_MAX : sense_raw[SENSE_W-1:0];
	end

	// Gain moves halfway toward target minus sense and is floored at minus one.
	always_comb begin
		gain_sum  = 27'(smoothed_gain_q) + 27'(target_gain) - 27'(sense_q);
		gain_half = gain_sum >>> 1;
		if (gain_half < 27'(GAIN_FLOOR)) begin
			gain_d = GAIN_FLOOR;
		end else begin
			gain_d = gain_half[GAIN_W-1:0];
		end
	end

	// Wet-scaled gain, rounded half up.
	always_comb begin
		g_rnd   = prod_q + G_RND;
		g_shift = g_rnd >>> 16;
	end

	// Limiter excess of the new sample over the slew window, Q.32.
	always_comb begin
		diff = DW'(in_sample) - DW'(prev_one_q);
		c32  = EXC_W'(diff) <<< CMP_SHIFT;
		t32  = EXC_W'({slew_threshold, 9'b0});
		if (c32 > t32) begin
			excess_d = c32 - t32;
		end else if (c32 < -t32) begin
			excess_d = c32 + t32;
		end else begin
			excess_d = '0;
		end
	end

	// Final adjustment, rounding half up, then saturation.
	always_comb begin
		o_rnd    = prod_q + O_RND;
		adj_full = o_rnd >>> OUT_SHIFT;
		adj      = adj_full[YW-1:0];
		y        = YW'(x_q) + adj;
		if (y > YW'(S_MAX)) begin
			y_sat = S_MAX;
		end else if (y < YW'(S_MIN)) begin
			y_sat = S_MIN;
		end else begin
			y_sat = y[SAMPLE_BITS-1:0];
		end
	end

	// Working registers; payload only, no reset.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q      <= in_sample;
			last_q   <= block_last;
			excess_q <= excess_d;
		end
		if (cmd.mul_en) begin
			prod_q <= prod_d;
		end
		if (cmd.acc_en) begin
			acc_q <= {prod_q[38:0], {RL_W{1'b0}}};
		end
		if (cmd.sense_en) begin
			sense_q <= sense_d;
		end
		if (cmd.g_en) begin
			g_q <= g_shift[GAIN_W-1:0];
		end
		if (cmd.commit) begin
			out_sample_q     <= y_sat;
			out_block_last_q <= last_q;
		end
	end

	// History and gain state, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_one_q      <= '0;
			prev_two_q      <= '0;
			smoothed_gain_q <= '0;
		end else begin
			if (cmd.gain_en) begin
				smoothed_gain_q <= gain_d;
			end
			if (cmd.commit) begin
				prev_two_q <= prev_one_q;
				prev_one_q <= x_q;
			end
		end
	end

	// Output valid: set on commit, cleared once the transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_blocked = out_valid_q && out_stall;
	assign out_valid       = out_valid_q;
	assign out_sample      = out_sample_q;
	assign out_block_last  = out_block_last_q;

	// The smoothed gain never falls below minus one.
	`SSEU_ASSERT_IMPL(a_gain_floor, 1'b1, smoothed_gain_q >= GAIN_FLOOR, "gain below floor")
	// A commit always presents a result in the next cycle.
	`SSEU_ASSERT_NEXT(a_commit_valid, cmd.commit, out_valid_q, "commit without valid result")
	// A result is dropped only after it was taken.
	`SSEU_ASSERT_IMPL(a_drop_taken, $fell(out_valid_q), $past(!out_stall), "result lost")

endmodule

[hdl/slew_sensing_air_enhancer_unit.sv]
// Top level of the slew-sensing air enhancer: configuration registers and
// the controller and datapath. Depends on sseu_pkg, sseu_ctrl and sseu_dp.
`timescale 1ns / 1ps

// Slew-sensing air enhancer. Each accepted sample gives exactly one result
// sample with its block marker. One sample is in work at a time: the result is
// written to the output register in the controller's last state, and the next
// input transaction can be taken in the cycle after that write, so a new sample
// is not accepted while the last one is still in work. The sample rate is set
// by the single shared 34x29 multiplier, used six times per sample, and by
// the divide-by-13 digit unit, which makes two passes of three 12-bit steps.
// A result waiting in the output register does not hold off the next input
// transaction, only its own commit. Configuration writes are always ready and
// take effect at once; write them only while no sample is in work.
module slew_sensing_air_enhancer_unit #(
	parameter int unsigned SAMPLE_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [SAMPLE_BITS-1:0]       in_sample,
	input  logic                                block_last,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [SAMPLE_BITS-1:0]       out_sample,
	output logic                                out_block_last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sseu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sseu_pkg::CFG_W-1:0]          cfg_data
);
	import sseu_pkg::*;

	logic signed [TGT_W-1:0] target_gain_q;
	logic        [THR_W-1:0] slew_threshold_q;
	logic        [INT_W-1:0] sense_intensity_q;
	logic        [WET_W-1:0] wet_mix_q;
	sseu_cmd_t               cmd;
	sseu_sts_t               sts;

	assign cfg_ready = 1'b1;

	// Configuration register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_gain_q     <= '0;
			slew_threshold_q  <= THRESH_RESET;
			sense_intensity_q <= '0;
			wet_mix_q         <= WET_ONE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TARGET: target_gain_q     <= cfg_data[TGT_W-1:0];
				REG_THRESH: slew_threshold_q  <= cfg_data[THR_W-1:0];
				REG_INTENS: sense_intensity_q <= cfg_data[INT_W-1:0];
				REG_WET:    wet_mix_q         <= cfg_data[WET_W-1:0];
				default:    target_gain_q     <= target_gain_q;
			endcase
		end
	end

	sseu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	sseu_dp #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_sample       (in_sample),
		.block_last      (block_last),
		.target_gain     (target_gain_q),
		.slew_threshold  (slew_threshold_q),
		.sense_intensity (sense_intensity_q),
		.wet_mix         (wet_mix_q),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_sample      (out_sample),
		.out_block_last  (out_block_last)
	);

endmodule
